### rtl/rkcf_pkg.sv
// Shared constants, types and reset values for the keyframe color fader.
`timescale 1ns / 1ps

package rkcf_pkg;

	localparam int KEYFRAME_COUNT = 6;
	localparam int KEY_REGS       = 6;
	localparam int SEG_W          = 3;
	localparam int STEP_W         = 12;
	localparam int CH_W           = 8;
	localparam int COLOR_W        = 32;
	localparam int LANES          = 4;
	localparam int CFG_IDX_W      = 3;
	localparam int MAG_W          = CH_W + STEP_W;
	localparam int DIV_STEPS      = CH_W;
	localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

	localparam logic [STEP_W-1:0] STEPS_RESET = 12'd500;

	localparam logic [CFG_IDX_W-1:0] REG_STEPS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY0  = 3'd1;

	localparam logic [COLOR_W-1:0] KEY_RESET [KEY_REGS] = '{
		32'hFF0000FF,
		32'h0000FF00,
		32'hFFFF0000,
		32'h000000FF,
		32'hFF00FF00,
		32'h00FF0000
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic take;
		logic rd;
		logic mul;
		logic div;
		logic load_out;
	} ctrl_cmd_t;

endpackage

### rtl/rkcf_ctrl.sv
// Sequencing state machine for the fader: accept, read, multiply, divide, output.
`timescale 1ns / 1ps

module rkcf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output rkcf_pkg::ctrl_cmd_t cmd
);
	import rkcf_pkg::*;

	localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	state_t               state_q;
	state_t               state_nxt;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.mul) begin
				cnt_q <= '0;
			end else if (cmd.div) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take  = 1'b1;
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd    = 1'b1;
				state_nxt = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				// The output register is free, or its transaction completes this cycle.
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

### rtl/rkcf_dp.sv
// Fader datapath: configuration storage, segment state, four channel lanes with serial divide.
`timescale 1ns / 1ps

module rkcf_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rkcf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rkcf_pkg::COLOR_W-1:0]    cfg_data,
	input  logic                            restart,
	input  rkcf_pkg::ctrl_cmd_t             cmd,
	output logic [rkcf_pkg::CH_W-1:0]       alpha_level,
	output logic [rkcf_pkg::CH_W-1:0]       red_level,
	output logic [rkcf_pkg::CH_W-1:0]       green_level,
	output logic [rkcf_pkg::CH_W-1:0]       blue_level,
	output logic [rkcf_pkg::SEG_W-1:0]      segment_now,
	output logic                            segment_done
);
	import rkcf_pkg::*;

	// Configuration storage.
	logic [STEP_W-1:0]  steps_q;
	logic [COLOR_W-1:0] key_mem [KEY_REGS];
	logic [KEY_REGS-1:0] key_vld_q;
	logic                key_wr;
	logic [SEG_W-1:0]    key_addr;

	// Fade position.
	logic [SEG_W-1:0]  seg_q;
	logic [STEP_W-1:0] step_q;

	// Per-transaction working registers.
	logic [SEG_W-1:0]   cur_seg_q;
	logic [SEG_W-1:0]   nxt_seg_q;
	logic [STEP_W-1:0]  k_q;
	logic               done_q;
	logic [COLOR_W-1:0] from_q;
	logic [COLOR_W-1:0] to_q;
	logic               up_q  [LANES];
	logic [STEP_W-1:0]  rem_q [LANES];
	logic [CH_W-1:0]    quo_q [LANES];

	logic [CH_W-1:0]    level_q [LANES];
	logic [SEG_W-1:0]   seg_out_q;
	logic               done_out_q;

	// Tick decode.
	logic [STEP_W-1:0] t_eff;
	logic [STEP_W-1:0] step_eff;
	logic [SEG_W-1:0]  seg_raw;
	logic [SEG_W-1:0]  seg_sel;
	logic [SEG_W-1:0]  nxt_sel;
	logic [STEP_W:0]   k_inc;
	logic [STEP_W-1:0] k_sel;
	logic              done_sel;

	// Lane arithmetic.
	logic [CH_W-1:0]   lane_f    [LANES];
	logic [CH_W-1:0]   lane_e    [LANES];
	logic              lane_up   [LANES];
	logic [CH_W-1:0]   lane_diff [LANES];
	logic [MAG_W-1:0]  lane_mag  [LANES];
	logic [MAG_W-1:0]  lane_dvd  [LANES];
	logic [STEP_W:0]   lane_trial [LANES];
	logic              lane_ge   [LANES];
	logic [STEP_W:0]   lane_sub  [LANES];
	logic [CH_W-1:0]   lane_res  [LANES];

	assign t_eff    = (steps_q == '0) ? STEP_W'(1) : steps_q;
	assign key_wr   = cfg_we && (cfg_index >= REG_KEY0)
		&& (cfg_index < CFG_IDX_W'(REG_KEY0 + KEY_REGS));
	assign key_addr = SEG_W'(cfg_index - REG_KEY0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q   <= STEPS_RESET;
			key_vld_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_STEPS) begin
				steps_q <= cfg_data[STEP_W-1:0];
			end else if (key_wr) begin
				key_vld_q[key_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (key_wr) begin
			key_mem[key_addr] <= cfg_data;
		end
	end

	// A keyframe never written reads as its reset color.
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			from_q <= key_vld_q[cur_seg_q] ? key_mem[cur_seg_q] : KEY_RESET[cur_seg_q];
			to_q   <= key_vld_q[nxt_seg_q] ? key_mem[nxt_seg_q] : KEY_RESET[nxt_seg_q];
		end
	end

	always_comb begin
		step_eff = restart ? '0 : step_q;
		seg_raw  = restart ? '0 : seg_q;
		seg_sel  = (seg_raw >= SEG_W'(KEYFRAME_COUNT)) ? '0 : seg_raw;
		nxt_sel  = (seg_sel == SEG_W'(KEYFRAME_COUNT - 1)) ? '0 : seg_sel + 1'b1;
		k_inc    = {1'b0, step_eff} + 1'b1;
		k_sel    = (k_inc > {1'b0, t_eff}) ? t_eff : k_inc[STEP_W-1:0];
		done_sel = (k_sel == t_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q  <= '0;
			step_q <= '0;
		end else if (cmd.take) begin
			seg_q  <= done_sel ? nxt_sel : seg_sel;
			step_q <= done_sel ? '0 : k_sel;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			cur_seg_q <= seg_sel;
			nxt_seg_q <= nxt_sel;
			k_q       <= k_sel;
			done_q    <= done_sel;
		end
	end

	// Descending fades divide (mag + t - 1) to round toward minus infinity.
	// Every quotient fits in one byte because k never exceeds t.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			lane_f[i]    = from_q[CH_W*(LANES-1-i) +: CH_W];
			lane_e[i]    = to_q[CH_W*(LANES-1-i) +: CH_W];
			lane_up[i]   = (lane_e[i] >= lane_f[i]);
			lane_diff[i] = lane_up[i] ? (lane_e[i] - lane_f[i]) : (lane_f[i] - lane_e[i]);
			lane_mag[i]  = {{STEP_W{1'b0}}, lane_diff[i]} * {{CH_W{1'b0}}, k_q};
			lane_dvd[i]  = lane_up[i] ? lane_mag[i]
				: (lane_mag[i] + {{CH_W{1'b0}}, t_eff} - MAG_W'(1));
			lane_trial[i] = {rem_q[i], quo_q[i][CH_W-1]};
			lane_ge[i]    = (lane_trial[i] >= {1'b0, t_eff});
			lane_sub[i]   = lane_trial[i] - {1'b0, t_eff};
			lane_res[i]   = up_q[i] ? (lane_f[i] + quo_q[i]) : (lane_f[i] - quo_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			if (cmd.mul) begin
				up_q[i]  <= lane_up[i];
				rem_q[i] <= lane_dvd[i][MAG_W-1:CH_W];
				quo_q[i] <= lane_dvd[i][CH_W-1:0];
			end else if (cmd.div) begin
				rem_q[i] <= lane_ge[i] ? lane_sub[i][STEP_W-1:0] : lane_trial[i][STEP_W-1:0];
				quo_q[i] <= {quo_q[i][CH_W-2:0], lane_ge[i]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			for (int i = 0; i < LANES; i++) begin
				level_q[i] <= lane_res[i];
			end
			seg_out_q  <= cur_seg_q;
			done_out_q <= done_q;
		end
	end

	assign alpha_level  = level_q[0];
	assign red_level    = level_q[1];
	assign green_level  = level_q[2];
	assign blue_level   = level_q[3];
	assign segment_now  = seg_out_q;
	assign segment_done = done_out_q;

endmodule

### rtl/rgb_keyframe_color_fader_top.sv
// Top level of the keyframe color fader: controller plus datapath.
`timescale 1ns / 1ps

// Each input transaction is one fade tick and yields one output transaction with
// the four interpolated ARGB channels, the segment index and a segment-done flag.
// A tick goes through these steps from acceptance until its result is loaded into
// the output register: accept and update the fade position, read the two
// keyframes, multiply, eight restoring divide steps (one quotient bit per
// cycle in each of four parallel channel lanes) and load the result. A new
// tick is accepted as soon as the previous result is loaded, even while that
// result still waits to be taken.
// Configuration writes must happen only while the block is idle.
module rgb_keyframe_color_fader_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rkcf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rkcf_pkg::COLOR_W-1:0]   cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [rkcf_pkg::CH_W-1:0]      alpha_level,
	output logic [rkcf_pkg::CH_W-1:0]      red_level,
	output logic [rkcf_pkg::CH_W-1:0]      green_level,
	output logic [rkcf_pkg::CH_W-1:0]      blue_level,
	output logic [rkcf_pkg::SEG_W-1:0]     segment_now,
	output logic                           segment_done
);
	import rkcf_pkg::*;

	ctrl_cmd_t cmd;

	rkcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	rkcf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.restart      (restart),
		.cmd          (cmd),
		.alpha_level  (alpha_level),
		.red_level    (red_level),
		.green_level  (green_level),
		.blue_level   (blue_level),
		.segment_now  (segment_now),
		.segment_done (segment_done)
	);

endmodule

### rtl/rkcf_checker.sv
// Port-level assertions for the keyframe color fader, bound to the top level.
`timescale 1ns / 1ps

module rkcf_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [rkcf_pkg::CH_W-1:0]      alpha_level,
	input logic [rkcf_pkg::CH_W-1:0]      red_level,
	input logic [rkcf_pkg::CH_W-1:0]      green_level,
	input logic [rkcf_pkg::CH_W-1:0]      blue_level,
	input logic [rkcf_pkg::SEG_W-1:0]     segment_now,
	input logic                           segment_done
);
	import rkcf_pkg::*;

	// The segment index reported never leaves the keyframe ring.
	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (segment_now < SEG_W'(KEYFRAME_COUNT)))
		else $error("segment_now outside the keyframe ring");

	// A tick keeps the block busy after its transaction is accepted.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted again right after a transaction");

	// No new result is raised right after an accepted tick.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (!out_valid || !out_stall)) |=> ##1 !$rose(out_valid))
		else $error("result produced too soon after an accepted tick");

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(alpha_level)
			&& $stable(red_level) && $stable(green_level) && $stable(blue_level)
			&& $stable(segment_now) && $stable(segment_done)))
		else $error("stalled result changed");

endmodule

bind rgb_keyframe_color_fader_top rkcf_checker u_rkcf_checker (.*);
